[rtl/u8e_pkg.sv]
// u8e_pkg: shared types and constants for the utf-8 encoder with row breaks
// used by u8e_front, u8e_queue, u8e_back and the top level
// no dependencies
`default_nettype none

package u8e_pkg;

  localparam int unsigned CP_BITS      = 32;
  localparam int unsigned ROW_BITS     = 10;
  localparam int unsigned QUEUE_DEPTH  = 2;   // power of two

  localparam logic [31:0] LIM_1B       = 32'h0000_0080;
  localparam logic [31:0] LIM_2B       = 32'h0000_0800;
  localparam logic [31:0] LIM_3B       = 32'h0001_0000;
  localparam logic [31:0] LIM_4B       = 32'h0011_0000;
  localparam logic [31:0] SURR_LO      = 32'h0000_D800;
  localparam logic [31:0] SURR_HI      = 32'h0000_DFFF;

  localparam logic [7:0]  LEAD_2B      = 8'd192;
  localparam logic [7:0]  LEAD_3B      = 8'd224;
  localparam logic [7:0]  LEAD_4B      = 8'd240;
  localparam logic [7:0]  CONT_BYTE    = 8'd128;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;
  localparam logic [7:0]  CHAR_LF      = 8'h0A;
  localparam logic [7:0]  ERR_BYTE     = 8'h00;
  localparam logic [9:0]  ROW_RESET    = 10'd80;

  // classified item handed from front to back
  typedef struct packed {
    logic [3:0][7:0] bytes;   // utf-8 bytes, first byte in entry 0
    logic [1:0]      nb_m1;   // utf-8 byte count minus one
    logic            crlf;    // row break follows
    logic            bad;     // not encodable
  } desc_t;

endpackage

`default_nettype wire

[rtl/u8e_front.sv]
// u8e_front: accepts code points, classifies and encodes them, tracks the column
// depends on u8e_pkg
`default_nettype none

module u8e_front #(
  parameter int unsigned COLUMN_BITS = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [u8e_pkg::ROW_BITS-1:0]   cfg_wdata,
  input  wire logic                           item_valid,
  input  wire logic [u8e_pkg::CP_BITS-1:0]    code_point,
  input  wire logic                           frame_start,
  input  wire logic                           q_full,
  output logic                                item_ready,
  output logic                                q_push,
  output u8e_pkg::desc_t                      q_desc
);

  localparam int unsigned EXT_BITS =
    (COLUMN_BITS > u8e_pkg::ROW_BITS) ? COLUMN_BITS : u8e_pkg::ROW_BITS;

  logic [u8e_pkg::ROW_BITS-1:0] row_len_r;
  logic [COLUMN_BITS-1:0]       col_r;
  logic [COLUMN_BITS-1:0]       col_nxt;
  logic [COLUMN_BITS-1:0]       col_base;
  logic [COLUMN_BITS-1:0]       col_inc;
  logic [COLUMN_BITS-1:0]       row_cmp;
  logic [EXT_BITS-1:0]          row_ext;
  logic                         is_bad;
  logic                         do_crlf;
  u8e_pkg::desc_t               desc;

  assign item_ready = !q_full;
  assign q_push     = item_valid && item_ready;
  assign q_desc     = desc;

  assign row_ext  = EXT_BITS'(row_len_r);
  assign row_cmp  = row_ext[COLUMN_BITS-1:0];
  assign col_base = frame_start ? '0 : col_r;
  assign col_inc  = col_base + {{(COLUMN_BITS-1){1'b0}}, 1'b1};

  assign is_bad = ((code_point >= u8e_pkg::SURR_LO) && (code_point <= u8e_pkg::SURR_HI))
                  || (code_point >= u8e_pkg::LIM_4B);
  assign do_crlf = !is_bad && (col_inc == row_cmp);

  always_comb begin
    desc       = '0;
    desc.bad   = is_bad;
    desc.crlf  = do_crlf;
    if (code_point < u8e_pkg::LIM_1B) begin
      desc.nb_m1    = 2'd0;
      desc.bytes[0] = code_point[7:0];
    end else if (code_point < u8e_pkg::LIM_2B) begin
      desc.nb_m1    = 2'd1;
      desc.bytes[0] = u8e_pkg::LEAD_2B | {3'b000, code_point[10:6]};
      desc.bytes[1] = u8e_pkg::CONT_BYTE | {2'b00, code_point[5:0]};
    end else if (code_point < u8e_pkg::LIM_3B) begin
      desc.nb_m1    = 2'd2;
      desc.bytes[0] = u8e_pkg::LEAD_3B | {4'b0000, code_point[15:12]};
      desc.bytes[1] = u8e_pkg::CONT_BYTE | {2'b00, code_point[11:6]};
      desc.bytes[2] = u8e_pkg::CONT_BYTE | {2'b00, code_point[5:0]};
    end else begin
      desc.nb_m1    = 2'd3;
      desc.bytes[0] = u8e_pkg::LEAD_4B | {5'b00000, code_point[20:18]};
      desc.bytes[1] = u8e_pkg::CONT_BYTE | {2'b00, code_point[17:12]};
      desc.bytes[2] = u8e_pkg::CONT_BYTE | {2'b00, code_point[11:6]};
      desc.bytes[3] = u8e_pkg::CONT_BYTE | {2'b00, code_point[5:0]};
    end
  end

  always_comb begin
    col_nxt = col_r;
    if (q_push) begin
      if (is_bad) begin
        col_nxt = col_base;
      end else if (do_crlf) begin
        col_nxt = '0;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= u8e_pkg::ROW_RESET;
      col_r     <= '0;
    end else begin
      if (cfg_we) begin
        row_len_r <= cfg_wdata;
      end
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/u8e_queue.sv]
// u8e_queue: short fifo of classified items between front and back
// depends on u8e_pkg
`default_nettype none

module u8e_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire u8e_pkg::desc_t push_desc,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output u8e_pkg::desc_t      head
);

  localparam int unsigned DEPTH   = u8e_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  u8e_pkg::desc_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + {{(PTR_W-1){1'b0}}, 1'b1};
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + {{(PTR_W-1){1'b0}}, 1'b1};
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CNT_W'(DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[rtl/u8e_back.sv]
// u8e_back: sends item bytes and any cr lf, one byte per cycle while out_ready
// depends on u8e_pkg
`default_nettype none

module u8e_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire u8e_pkg::desc_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_bad
);

  logic [2:0] pos_r;
  logic [2:0] pos_nxt;
  logic [2:0] last_idx;
  logic [2:0] nb_m1_ext;
  logic [7:0] sel_byte;
  logic       sel_last;
  logic       slot_free;
  logic       emit;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       bad_r;

  assign nb_m1_ext = {1'b0, q_head.nb_m1};
  assign last_idx  = q_head.bad ? 3'd0 : (nb_m1_ext + (q_head.crlf ? 3'd2 : 3'd0));
  assign sel_last  = (pos_r == last_idx);
  assign slot_free = !valid_r || out_ready;
  assign emit      = slot_free && !q_empty;
  assign q_pop     = emit && sel_last;

  always_comb begin
    if (q_head.bad) begin
      sel_byte = u8e_pkg::ERR_BYTE;
    end else if (pos_r <= nb_m1_ext) begin
      sel_byte = q_head.bytes[pos_r[1:0]];
    end else if (pos_r == (nb_m1_ext + 3'd1)) begin
      sel_byte = u8e_pkg::CHAR_CR;
    end else begin
      sel_byte = u8e_pkg::CHAR_LF;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (emit) begin
      pos_nxt = sel_last ? 3'd0 : (pos_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= sel_byte;
      last_r <= sel_last;
      bad_r  <= q_head.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= 3'd0;
    end else begin
      if (slot_free) begin
        valid_r <= !q_empty;
      end
      pos_r <= pos_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_bad   = bad_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 3'd5)
    else $error("byte position out of range");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && bad_r) |-> (last_r && (byte_r == u8e_pkg::ERR_BYTE)))
    else $error("error result not a single zero byte");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (pos_r == 3'd0))
    else $error("position not restarted after item");

endmodule

`default_nettype wire

[rtl/utf8_encoder_with_row_breaks_unit.sv]
// utf8_encoder_with_row_breaks_unit: top level of the utf-8 encoder with row breaks
// depends on u8e_pkg, u8e_front, u8e_queue, u8e_back
//
// in_* channel: one transaction per code point; in_tdata carries the code point and
//   in_tuser marks the start of a frame, which clears the column count first.
// out_* channel: one transaction per output byte; out_tlast ends the bytes of one
//   code point, out_tuser flags a code point that cannot be encoded (a surrogate or
//   0x110000 and above), sent as a single zero byte with no column change.
// cfg_we/cfg_wdata write the row length (reset 80); after that many encoded code
//   points a cr lf pair is appended. write it only while the block is idle.
// the first byte of a code point is written into the queue, then into the output
//   register of u8e_back, before it shows on out_*.
// throughput: the output side moves one byte per cycle while out_tready is high;
//   a code point makes 1 to 6 bytes (utf-8 length 1-4 plus 2 for a row break);
//   the input side keeps accepting while a two-entry queue has room.
// reset empties the queue, drops out_tvalid, clears the column count and sets the
//   row length back to 80.
// when out_tready is low the current byte holds and the queue fills, after which
//   in_tready drops.

`default_nettype none

module utf8_encoder_with_row_breaks_unit #(
  parameter int unsigned COLUMN_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [u8e_pkg::ROW_BITS-1:0]  cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,   // [31:0] code_point
  input  wire logic                          in_tuser,   // [0] frame_start
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] out_byte
  output logic                               out_tlast,
  output logic                               out_tuser   // [0] bad_code_point
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  u8e_pkg::desc_t q_in;
  u8e_pkg::desc_t q_head;

  u8e_front #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (in_tvalid),
    .code_point  (in_tdata),
    .frame_start (in_tuser),
    .q_full      (q_full),
    .item_ready  (in_tready),
    .q_push      (q_push),
    .q_desc      (q_in)
  );

  u8e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  u8e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_bad   (out_tuser)
  );

endmodule

`default_nettype wire

[test/utf8_encoder_with_row_breaks_unit_tb.sv]
// utf8_encoder_with_row_breaks_unit_tb: self-checking bench for the utf-8 encoder with row breaks
// streams code points through in_*, predicts the utf-8 bytes and row breaks and checks out_*
// depends on u8e_pkg and utf8_encoder_with_row_breaks_unit
`timescale 1ns / 1ps

module utf8_encoder_with_row_breaks_unit_tb;

  localparam int COLUMN_BITS = 10;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } utf8_byte_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [u8e_pkg::ROW_BITS-1:0] cfg_wdata;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [31:0]                  in_tdata;   // [31:0] code_point
  logic                         in_tuser;   // [0] frame_start
  logic                         out_tvalid;
  logic                         out_tready;
  logic [7:0]                   out_tdata;  // [7:0] out_byte
  logic                         out_tlast;
  logic                         out_tuser;  // [0] bad_code_point

  utf8_byte_t                   bytes_due[$];
  logic [COLUMN_BITS-1:0]       col_count = '0;
  logic [COLUMN_BITS-1:0]       row_len;
  int                           error_count = 0;
  int                           cycle_count = 0;
  bit                           in_gaps_on;
  bit                           ready_noise;
  bit                           hold_go = 1'b0;
  int                           hold_len;

  utf8_encoder_with_row_breaks_unit #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
    error_count++;
  endtask

  task automatic predict_utf8(input logic [31:0] cp, input logic fs);
    logic [7:0] seq[$];
    utf8_byte_t b;
    if (fs)
      col_count = '0;
    if ((cp >= u8e_pkg::SURR_LO && cp <= u8e_pkg::SURR_HI) || cp >= u8e_pkg::LIM_4B) begin
      b.data = u8e_pkg::ERR_BYTE;
      b.last = 1'b1;
      b.bad  = 1'b1;
      bytes_due.push_back(b);
    end else begin
      if (cp < u8e_pkg::LIM_1B) begin
        seq.push_back(cp[7:0]);
      end else if (cp < u8e_pkg::LIM_2B) begin
        seq.push_back(u8e_pkg::LEAD_2B + 8'(cp >> 6));
        seq.push_back(u8e_pkg::CONT_BYTE + 8'(cp & 32'h3f));
      end else if (cp < u8e_pkg::LIM_3B) begin
        seq.push_back(u8e_pkg::LEAD_3B + 8'(cp >> 12));
        seq.push_back(u8e_pkg::CONT_BYTE + 8'((cp >> 6) & 32'h3f));
        seq.push_back(u8e_pkg::CONT_BYTE + 8'(cp & 32'h3f));
      end else begin
        seq.push_back(u8e_pkg::LEAD_4B + 8'(cp >> 18));
        seq.push_back(u8e_pkg::CONT_BYTE + 8'((cp >> 12) & 32'h3f));
        seq.push_back(u8e_pkg::CONT_BYTE + 8'((cp >> 6) & 32'h3f));
        seq.push_back(u8e_pkg::CONT_BYTE + 8'(cp & 32'h3f));
      end
      col_count = col_count + 1'b1;
      if (col_count == row_len) begin
        seq.push_back(u8e_pkg::CHAR_CR);
        seq.push_back(u8e_pkg::CHAR_LF);
        col_count = '0;
      end
      foreach (seq[k]) begin
        b.data = seq[k];
        b.last = (k == seq.size() - 1);
        b.bad  = 1'b0;
        bytes_due.push_back(b);
      end
    end
  endtask

  // input transactions feed the predictor, output transactions are checked in order
  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_utf8(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (bytes_due.size() == 0) begin
          report_mismatch("unexpected byte", {24'd0, out_tdata}, 32'd0);
        end else begin
          want = bytes_due.pop_front();
          if (out_tdata !== want.data)
            report_mismatch("out_byte", {24'd0, out_tdata}, {24'd0, want.data});
          if (out_tlast !== want.last)
            report_mismatch("last_in_run", {31'd0, out_tlast}, {31'd0, want.last});
          if (out_tuser !== want.bad)
            report_mismatch("bad_code_point", {31'd0, out_tuser}, {31'd0, want.bad});
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int r;
    int hold_left;
    bit hold_seen;
    hold_left  = 0;
    hold_seen  = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go != hold_seen) begin
        hold_left = hold_len;
        hold_seen = hold_go;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (ready_noise) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready = 1'b1;
        end else if (r < 95) begin
          out_tready = 1'b0;
          hold_left  = $urandom_range(0, 2);
        end else begin
          out_tready = 1'b0;
          hold_left  = $urandom_range(10, 30);
        end
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!in_gaps_on || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [31:0] random_scalar();
    logic [31:0] cp;
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(0, 'h7f);
      1: cp = $urandom_range('h80, 'h7ff);
      2: cp = $urandom_range('h800, 'hffff);
      default: cp = $urandom_range('h10000, 'h10ffff);
    endcase
    if (cp >= u8e_pkg::SURR_LO && cp <= u8e_pkg::SURR_HI)
      cp = cp - 32'h800;
    return cp;
  endfunction

  function automatic logic [31:0] random_bad_value();
    logic [31:0] cp;
    if ($urandom_range(0, 1))
      cp = $urandom_range('hd800, 'hdfff);
    else
      cp = $urandom();
    return cp;
  endfunction

  task automatic send_code_point(input logic [31:0] cp, input logic fs);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = cp;
    in_tuser  = fs;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_row_length(input logic [u8e_pkg::ROW_BITS-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    row_len   = value;
  endtask

  // utf-8 length boundaries and rejected values at the reset row length
  task automatic test_encoding_bounds();
    logic [31:0] points[$];
    in_gaps_on  = 1'b0;
    ready_noise = 1'b0;
    points = '{32'h0, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hd7ff, 32'hd800, 32'hdfff,
               32'he000, 32'hffff, 32'h10000, 32'h10ffff, 32'h110000, 32'hffffffff};
    foreach (points[i])
      send_code_point(points[i], (i % 5) == 0);
    wait_idle();
  endtask

  // break after every encodable code point, then frame restart on a rejected value
  task automatic test_row_breaks();
    set_row_length(10'd1);
    send_code_point(32'h41, 1'b0);
    send_code_point(32'h10ffff, 1'b0);
    send_code_point(32'hd800, 1'b0);
    send_code_point(32'h7ff, 1'b0);
    wait_idle();
    set_row_length(10'd3);
    send_code_point(32'h61, 1'b1);
    send_code_point(32'h62, 1'b0);
    send_code_point(32'h110000, 1'b1);
    send_code_point(32'h63, 1'b0);
    send_code_point(32'h64, 1'b0);
    send_code_point(32'h65, 1'b0);
    wait_idle();
  endtask

  // receiver holds off while 4-byte code points keep coming
  task automatic test_backpressure();
    set_row_length(10'd7);
    in_gaps_on  = 1'b0;
    ready_noise = 1'b1;
    hold_len    = 80;
    hold_go     = ~hold_go;
    repeat (20)
      send_code_point($urandom_range('h10000, 'h10ffff), 1'b0);
    wait_idle();
  endtask

  task automatic test_random_rows();
    logic [u8e_pkg::ROW_BITS-1:0] lengths[$];
    logic [31:0] cp;
    logic fs;
    lengths = '{10'd2, 10'd3, 10'd5, 10'd16, 10'd80, 10'd1023, 10'd1};
    foreach (lengths[i]) begin
      set_row_length(lengths[i]);
      in_gaps_on  = (i % 3) != 1;
      ready_noise = (i % 3) != 2;
      repeat (54) begin
        cp = ($urandom_range(0, 99) < 85) ? random_scalar() : random_bad_value();
        fs = $urandom_range(0, 99) < 10;
        send_code_point(cp, fs);
      end
      wait_idle();
    end
  endtask

  // row length lowered below the count, then zero: no break until the count wraps
  task automatic test_count_wrap();
    set_row_length(10'd30);
    in_gaps_on  = 1'b0;
    ready_noise = 1'b1;
    send_code_point(random_scalar(), 1'b1);
    repeat (9)
      send_code_point(random_scalar(), 1'b0);
    wait_idle();
    set_row_length(10'd4);
    repeat (20)
      send_code_point(random_scalar(), 1'b0);
    wait_idle();
    set_row_length(10'd0);
    repeat (10)
      send_code_point(random_scalar(), 1'b0);
    wait_idle();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    row_len      = u8e_pkg::ROW_RESET;
    in_gaps_on   = 1'b0;
    ready_noise  = 1'b0;
    hold_len     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_encoding_bounds();
    test_row_breaks();
    test_backpressure();
    test_random_rows();
    test_count_wrap();
    wait_idle();

    if (bytes_due.size() != 0)
      report_mismatch("bytes never sent", 32'(bytes_due.size()), 32'd0);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[utf8_encoder_with_row_breaks_unit.f]
rtl/u8e_pkg.sv
rtl/u8e_front.sv
rtl/u8e_queue.sv
rtl/u8e_back.sv
rtl/utf8_encoder_with_row_breaks_unit.sv
test/utf8_encoder_with_row_breaks_unit_tb.sv
